@@ sv/lsw_pkg.sv @@
// ============================================================================
// lsw_pkg: shared types and constants of the LRU sector write buffer
// Field widths, register indexes, result codes and the transfer records that
// pass between the request front end, the command queue and the cache engine.
// ============================================================================
`default_nettype none

package lsw_pkg;

    localparam int CAPACITY_DEF         = 1024;
    localparam int LOOKUP_BUCKETS_DEF   = 2048;
    localparam int QUEUE_DEPTH_DEF      = 4;
    localparam int MAX_REQ_SECTORS      = 64;
    localparam int MAX_SECTORS_PER_PAGE = 32;

    localparam int SPP_W      = 6;
    localparam int LIMIT_W    = 11;
    localparam int CFG_DATA_W = 11;
    localparam int COUNT_W    = 8;
    localparam int PAGE_W     = 32;
    localparam int MASK_W     = 32;
    localparam int REMAIN_W   = $clog2(MAX_REQ_SECTORS + 1);

    localparam logic CFG_IDX_SECTORS_PER_PAGE = 1'b0;
    localparam logic CFG_IDX_BUFFER_LIMIT     = 1'b1;

    typedef enum logic [2:0] {
        OC_READ_HIT     = 3'd0,
        OC_READ_PARTIAL = 3'd1,
        OC_READ_MISS    = 3'd2,
        OC_WRITE_HIT    = 3'd3,
        OC_WRITE_INSERT = 3'd4,
        OC_REJECTED     = 3'd5
    } outcome_t;

    // One page of work handed from the front end to the engine.
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [MASK_W-1:0] mask;
        logic              is_write;
        logic              reject;
        logic              last;
    } page_cmd_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic [MASK_W-1:0] sector_mask;
        outcome_t          outcome;
        logic              writeback_valid;
        logic [PAGE_W-1:0] writeback_page;
        logic [MASK_W-1:0] writeback_mask;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

@@ sv/lru_sector_write_buffer_top.sv @@
// ============================================================================
// lru_sector_write_buffer_top: LRU write-back page buffer with sector masks
// Walks the pages of each host request, looks every page up in an LRU buffer
// and reports one result per page, with any dirty write-back it caused.
// ============================================================================
`default_nettype none

// Each request transfer on the s_ channel yields one result transfer per page
// it touches (the last one carries tlast), or a single rejection result when
// its sector count is zero or above the request limit. After reset the block
// first clears its bucket table, one bucket a cycle, and s_tready stays low
// until that pass ends; configuration writes are taken during that pass.
// The front end takes a request, runs the bit-serial division of the start
// sector by the page size, and then issues one page a cycle into a short
// queue while the queue has room. The engine behind it works one page at a
// time against single-ported tables; each extra bucket probed lengthens a
// lookup, and when an entry is evicted the engine makes a second lookup and
// scans the buckets behind the freed one up to the next empty one, moving
// back those that belong in the hole. The front end and the engine overlap,
// so a long request is paced by the engine. A finished result waits in an
// output register while the engine goes on with the next page.

module lru_sector_write_buffer_top #(
    parameter int CAPACITY       = lsw_pkg::CAPACITY_DEF,
    parameter int LOOKUP_BUCKETS = lsw_pkg::LOOKUP_BUCKETS_DEF,
    parameter int QUEUE_DEPTH    = lsw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Request channel.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [39:0]                       s_tdata,  // start_sector, sector_count
    input  wire logic                              s_tuser,  // req_type
    // Result channel.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // page_number, sector_mask, writeback_page, writeback_mask
    output logic [127:0]                           m_tdata,
    output logic [3:0]                             m_tuser,  // outcome, writeback_valid
    output logic                                   m_tlast,
    // Configuration write port.
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [lsw_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int BKT_W  = $clog2(LOOKUP_BUCKETS);
    localparam int BV_W   = $clog2(CAPACITY + 1);
    localparam int QW     = $bits(lsw_pkg::page_cmd_t) + BKT_W;
    localparam int LIMIT_CAP = (CAPACITY < LOOKUP_BUCKETS - 1) ? CAPACITY
                                                               : LOOKUP_BUCKETS - 1;

    logic [lsw_pkg::SPP_W-1:0]   spp_reg;
    logic [lsw_pkg::LIMIT_W-1:0] limit_reg;
    logic [lsw_pkg::SPP_W-1:0]   page_size;
    logic [BV_W-1:0]             limit_eff;

    logic                        hold_off;
    logic                        fq_valid, fq_ready;
    lsw_pkg::page_cmd_t          f_cmd;
    logic [BKT_W-1:0]            f_home;
    logic                        qe_valid, qe_ready;
    logic [QW-1:0]               qe_data;
    lsw_pkg::page_cmd_t          e_cmd;
    logic [BKT_W-1:0]            e_home;
    lsw_pkg::result_t            res;

    // Configuration registers; an index beyond the list cannot be addressed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spp_reg   <= lsw_pkg::SPP_W'(4);
            limit_reg <= lsw_pkg::LIMIT_W'(1024);
        end else if (cfg_wr_en) begin
            if (cfg_index == lsw_pkg::CFG_IDX_SECTORS_PER_PAGE) begin
                spp_reg <= cfg_wr_data[lsw_pkg::SPP_W-1:0];
            end else begin
                limit_reg <= cfg_wr_data[lsw_pkg::LIMIT_W-1:0];
            end
        end
    end

    // A page size of zero acts as one sector; values above 32 are capped at 32.
    always_comb begin
        priority if (spp_reg == '0) begin
            page_size = lsw_pkg::SPP_W'(1);
        end else if (spp_reg > lsw_pkg::SPP_W'(lsw_pkg::MAX_SECTORS_PER_PAGE)) begin
            page_size = lsw_pkg::SPP_W'(lsw_pkg::MAX_SECTORS_PER_PAGE);
        end else begin
            page_size = spp_reg;
        end
    end

    // The limit is at least one and never above the table can hold.
    always_comb begin
        priority if (limit_reg == '0) begin
            limit_eff = BV_W'(1);
        end else if (32'(limit_reg) > 32'(LIMIT_CAP)) begin
            limit_eff = BV_W'(LIMIT_CAP);
        end else begin
            limit_eff = BV_W'(limit_reg);
        end
    end

    lsw_front #(
        .LOOKUP_BUCKETS (LOOKUP_BUCKETS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .hold_off  (hold_off),
        .page_size (page_size),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (f_cmd),
        .cmd_home  (f_home)
    );

    lsw_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({f_home, f_cmd}),
        .out_valid (qe_valid),
        .out_ready (qe_ready),
        .out_data  (qe_data)
    );

    assign e_cmd  = qe_data[$bits(lsw_pkg::page_cmd_t)-1:0];
    assign e_home = qe_data[QW-1:$bits(lsw_pkg::page_cmd_t)];

    lsw_engine #(
        .CAPACITY       (CAPACITY),
        .LOOKUP_BUCKETS (LOOKUP_BUCKETS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limit     (limit_eff),
        .cmd_valid (qe_valid),
        .cmd_ready (qe_ready),
        .cmd       (e_cmd),
        .cmd_home  (e_home),
        .clearing  (hold_off),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.writeback_mask, res.writeback_page, res.sector_mask, res.page_number};
    assign m_tuser = {res.writeback_valid, res.outcome};
    assign m_tlast = res.last;

endmodule

`default_nettype wire

@@ sv/lsw_front.sv @@
// ============================================================================
// lsw_front: request front end
// Divides the start sector by the page size bit by bit, reduces the first
// page to its home bucket on the way, then walks the pages of the request.
// ============================================================================
`default_nettype none

module lsw_front #(
    parameter int LOOKUP_BUCKETS = lsw_pkg::LOOKUP_BUCKETS_DEF,
    localparam int BKT_W = $clog2(LOOKUP_BUCKETS)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [39:0]                 s_tdata,
    input  wire logic                        s_tuser,
    input  wire logic                        hold_off,
    input  wire logic [lsw_pkg::SPP_W-1:0]   page_size,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output lsw_pkg::page_cmd_t               cmd,
    output logic [BKT_W-1:0]                 cmd_home
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_WALK = 3'b100
    } front_state_t;

    front_state_t                       state_reg, state_next;
    logic                               is_write_reg, is_write_next;
    logic                               reject_reg, reject_next;
    logic                               first_reg, first_next;
    logic [31:0]                        quot_reg, quot_next;
    logic [4:0]                         rem_reg, rem_next;
    logic [BKT_W-1:0]                   home_reg, home_next;
    logic [4:0]                         step_reg, step_next;
    logic [lsw_pkg::SPP_W-1:0]          spp_reg, spp_next;
    logic [lsw_pkg::REMAIN_W-1:0]       remain_reg, remain_next;

    logic [5:0]                         div_shift;
    logic                               div_ge;
    logic [5:0]                         div_sub;
    logic [BKT_W:0]                     mod_shift;
    logic                               mod_ge;
    logic [BKT_W:0]                     mod_sub;
    logic [4:0]                         lo;
    logic [5:0]                         room;
    logic [6:0]                         take;
    logic [32:0]                        ones;
    logic [31:0]                        mask;
    logic                               is_last;
    logic                               accept;

    assign s_tready = (state_reg == F_IDLE) && !hold_off;
    assign accept   = s_tvalid && s_tready;

    // One quotient bit a step; each bit also feeds the home bucket remainder.
    assign div_shift = {rem_reg, quot_reg[31]};
    assign div_ge    = (div_shift >= spp_reg);
    assign div_sub   = div_shift - spp_reg;
    assign mod_shift = {home_reg, div_ge};
    assign mod_ge    = (mod_shift >= (BKT_W + 1)'(LOOKUP_BUCKETS));
    assign mod_sub   = mod_shift - (BKT_W + 1)'(LOOKUP_BUCKETS);

    assign lo      = first_reg ? rem_reg : 5'd0;
    assign room    = spp_reg - {1'b0, lo};
    assign take    = (7'(remain_reg) < {1'b0, room}) ? 7'(remain_reg) : {1'b0, room};
    assign ones    = (33'd1 << take[5:0]) - 33'd1;
    assign mask    = ones[31:0] << lo;
    assign is_last = (7'(remain_reg) == take);

    assign cmd_valid     = (state_reg == F_WALK);
    assign cmd.page      = quot_reg;
    assign cmd.mask      = reject_reg ? '0 : mask;
    assign cmd.is_write  = is_write_reg;
    assign cmd.reject    = reject_reg;
    assign cmd.last      = reject_reg || is_last;
    assign cmd_home      = home_reg;

    always_comb begin
        state_next    = state_reg;
        is_write_next = is_write_reg;
        reject_next   = reject_reg;
        first_next    = first_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        home_next     = home_reg;
        step_next     = step_reg;
        spp_next      = spp_reg;
        remain_next   = remain_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    is_write_next = s_tuser;
                    reject_next   = (s_tdata[39:32] == 8'd0) ||
                                    (s_tdata[39:32] > 8'(lsw_pkg::MAX_REQ_SECTORS));
                    quot_next     = s_tdata[31:0];
                    rem_next      = '0;
                    home_next     = '0;
                    step_next     = '0;
                    first_next    = 1'b1;
                    spp_next      = page_size;
                    remain_next   = s_tdata[32 +: lsw_pkg::REMAIN_W];
                    state_next    = F_DIV;
                end
            end
            F_DIV: begin
                quot_next = {quot_reg[30:0], div_ge};
                rem_next  = div_ge ? div_sub[4:0] : div_shift[4:0];
                home_next = mod_ge ? mod_sub[BKT_W-1:0] : mod_shift[BKT_W-1:0];
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    state_next = F_WALK;
                end
            end
            F_WALK: begin
                if (cmd_ready) begin
                    if (reject_reg || is_last) begin
                        state_next = F_IDLE;
                    end else begin
                        quot_next   = quot_reg + 32'd1;
                        home_next   = (home_reg == BKT_W'(LOOKUP_BUCKETS - 1)) ? '0
                                                                             : home_reg + 1'b1;
                        remain_next = remain_reg - take[lsw_pkg::REMAIN_W-1:0];
                        first_next  = 1'b0;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        is_write_reg <= is_write_next;
        reject_reg   <= reject_next;
        first_reg    <= first_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        home_reg     <= home_next;
        step_reg     <= step_next;
        spp_reg      <= spp_next;
        remain_reg   <= remain_next;
    end

endmodule

`default_nettype wire

@@ sv/lsw_queue.sv @@
// ============================================================================
// lsw_queue: page command queue
// A short first-in first-out store that lets the front end run ahead of the
// cache engine.
// ============================================================================
`default_nettype none

module lsw_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lsw_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/lsw_engine.sv @@
// ============================================================================
// lsw_engine: cache engine
// Looks each page up in the open-addressed bucket table, updates the entry
// store and the LRU chain, evicts and inserts, and registers the result.
// ============================================================================
`default_nettype none

module lsw_engine #(
    parameter int CAPACITY       = lsw_pkg::CAPACITY_DEF,
    parameter int LOOKUP_BUCKETS = lsw_pkg::LOOKUP_BUCKETS_DEF,
    localparam int BKT_W  = $clog2(LOOKUP_BUCKETS),
    localparam int SLOT_W = $clog2(CAPACITY),
    localparam int BV_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [BV_W-1:0]    limit,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire lsw_pkg::page_cmd_t cmd,
    input  wire logic [BKT_W-1:0]   cmd_home,
    output logic                    clearing,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output lsw_pkg::result_t        res
);

    typedef enum logic [16:0] {
        B_CLEAR   = 17'h00001,
        B_IDLE    = 17'h00002,
        B_LK_BKT  = 17'h00004,
        B_LK_ENT  = 17'h00008,
        B_LK_CMP  = 17'h00010,
        B_EXEC    = 17'h00020,
        B_MRU1    = 17'h00040,
        B_MRU2    = 17'h00080,
        B_EV_RD   = 17'h00100,
        B_RM_BKT  = 17'h00200,
        B_RM_ENT  = 17'h00400,
        B_RM_CMP  = 17'h00800,
        B_RM_ZERO = 17'h01000,
        B_INS     = 17'h02000,
        B_BI_BKT  = 17'h04000,
        B_BI_CHK  = 17'h08000,
        B_OUT     = 17'h10000
    } engine_state_t;

    // Storage: bucket table and entry store, registered reads.
    logic [BV_W-1:0]   bucket_mem [LOOKUP_BUCKETS];
    logic [31:0]       page_mem   [CAPACITY];
    logic [BKT_W-1:0]  home_mem   [CAPACITY];
    logic [31:0]       stored_mem [CAPACITY];
    logic [31:0]       dirty_mem  [CAPACITY];
    logic [SLOT_W-1:0] prev_mem   [CAPACITY];
    logic [SLOT_W-1:0] next_mem   [CAPACITY];

    logic [BV_W-1:0]   bkt_rd_reg;
    logic [31:0]       page_rd_reg;
    logic [BKT_W-1:0]  home_rd_reg;
    logic [31:0]       stored_rd_reg;
    logic [31:0]       dirty_rd_reg;
    logic [SLOT_W-1:0] prev_rd_reg;
    logic [SLOT_W-1:0] next_rd_reg;

    logic              bkt_re, bkt_we, ent_re, ent_we, prev_we, next_we;
    logic [BKT_W-1:0]  bkt_raddr, bkt_waddr;
    logic [BV_W-1:0]   bkt_wdata;
    logic [SLOT_W-1:0] ent_raddr, ent_waddr, prev_waddr, next_waddr;
    logic [31:0]       ent_wpage, ent_wstored, ent_wdirty;
    logic [SLOT_W-1:0] prev_wdata, next_wdata;

    engine_state_t      state_reg, state_next;
    lsw_pkg::page_cmd_t cmd_reg, cmd_next;
    logic [BKT_W-1:0]   home_reg, home_next;
    logic [31:0]        key_reg, key_next;
    logic [BKT_W-1:0]   probe_reg, probe_next;
    logic               victim_mode_reg, victim_mode_next;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  victim_reg, victim_next;
    logic               evict_reg, evict_next;
    logic [BKT_W-1:0]   hole_reg, hole_next;
    logic [SLOT_W-1:0]  mru_reg, mru_next;
    logic [SLOT_W-1:0]  lru_reg, lru_next;
    logic [BV_W-1:0]    occ_reg, occ_next;
    lsw_pkg::outcome_t  outcome_reg, outcome_next;
    logic               wb_valid_reg, wb_valid_next;
    logic [31:0]        wb_page_reg, wb_page_next;
    logic [31:0]        wb_mask_reg, wb_mask_next;
    lsw_pkg::result_t   res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic [SLOT_W-1:0]  bkt_slot;
    logic [BKT_W-1:0]   probe_inc;
    logic [BKT_W-1:0]   hole_inc;
    logic               move;
    logic [BV_W-1:0]    occ_after;

    function automatic logic [BKT_W-1:0] wrap_inc(input logic [BKT_W-1:0] b);
        wrap_inc = (b == BKT_W'(LOOKUP_BUCKETS - 1)) ? '0 : b + 1'b1;
    endfunction

    assign bkt_slot  = SLOT_W'(bkt_rd_reg - 1'b1);
    assign probe_inc = wrap_inc(probe_reg);
    assign hole_inc  = wrap_inc(hole_reg);
    assign occ_after = evict_reg ? occ_reg - 1'b1 : occ_reg;

    // Backward-shift deletion: does the entry seen at probe_reg belong in the hole?
    always_comb begin
        if (probe_reg > hole_reg) begin
            move = (home_rd_reg <= hole_reg) || (home_rd_reg > probe_reg);
        end else begin
            move = (home_rd_reg <= hole_reg) && (home_rd_reg > probe_reg);
        end
    end

    assign clearing  = (state_reg == B_CLEAR);
    assign cmd_ready = (state_reg == B_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        home_next        = home_reg;
        key_next         = key_reg;
        probe_next       = probe_reg;
        victim_mode_next = victim_mode_reg;
        found_next       = found_reg;
        slot_next        = slot_reg;
        victim_next      = victim_reg;
        evict_next       = evict_reg;
        hole_next        = hole_reg;
        mru_next         = mru_reg;
        lru_next         = lru_reg;
        occ_next         = occ_reg;
        outcome_next     = outcome_reg;
        wb_valid_next    = wb_valid_reg;
        wb_page_next     = wb_page_reg;
        wb_mask_next     = wb_mask_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && !res_ready;

        bkt_re      = 1'b0;
        bkt_raddr   = probe_reg;
        bkt_we      = 1'b0;
        bkt_waddr   = probe_reg;
        bkt_wdata   = '0;
        ent_re      = 1'b0;
        ent_raddr   = bkt_slot;
        ent_we      = 1'b0;
        ent_waddr   = slot_reg;
        ent_wpage   = cmd_reg.page;
        ent_wstored = stored_rd_reg | cmd_reg.mask;
        ent_wdirty  = dirty_rd_reg | cmd_reg.mask;
        prev_we     = 1'b0;
        prev_waddr  = next_rd_reg;
        prev_wdata  = prev_rd_reg;
        next_we     = 1'b0;
        next_waddr  = prev_rd_reg;
        next_wdata  = next_rd_reg;

        unique case (state_reg)
            B_CLEAR: begin
                bkt_we     = 1'b1;
                probe_next = probe_inc;
                if (probe_reg == BKT_W'(LOOKUP_BUCKETS - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (cmd_valid) begin
                    cmd_next         = cmd;
                    home_next        = cmd_home;
                    key_next         = cmd.page;
                    probe_next       = cmd_home;
                    victim_mode_next = 1'b0;
                    found_next       = 1'b0;
                    wb_valid_next    = 1'b0;
                    wb_page_next     = '0;
                    wb_mask_next     = '0;
                    if (cmd.reject) begin
                        outcome_next = lsw_pkg::OC_REJECTED;
                        state_next   = B_OUT;
                    end else begin
                        state_next = B_LK_BKT;
                    end
                end
            end
            B_LK_BKT: begin
                bkt_re     = 1'b1;
                state_next = B_LK_ENT;
            end
            B_LK_ENT: begin
                if (bkt_rd_reg == '0) begin
                    found_next = 1'b0;
                    state_next = victim_mode_reg ? B_INS : B_EXEC;
                end else begin
                    ent_re     = 1'b1;
                    state_next = B_LK_CMP;
                end
            end
            B_LK_CMP: begin
                if (page_rd_reg == key_reg) begin
                    slot_next = bkt_slot;
                    if (victim_mode_reg) begin
                        bkt_we     = 1'b1;
                        hole_next  = probe_reg;
                        probe_next = probe_inc;
                        state_next = B_RM_BKT;
                    end else begin
                        found_next = 1'b1;
                        state_next = B_EXEC;
                    end
                end else begin
                    probe_next = probe_inc;
                    state_next = B_LK_BKT;
                end
            end
            B_EXEC: begin
                if (!cmd_reg.is_write) begin
                    if (!found_reg) begin
                        outcome_next = lsw_pkg::OC_READ_MISS;
                        state_next   = B_OUT;
                    end else if ((stored_rd_reg & cmd_reg.mask) == cmd_reg.mask) begin
                        outcome_next = lsw_pkg::OC_READ_HIT;
                        state_next   = B_MRU1;
                    end else begin
                        outcome_next = lsw_pkg::OC_READ_PARTIAL;
                        state_next   = B_OUT;
                    end
                end else if (found_reg) begin
                    ent_we       = 1'b1;
                    outcome_next = lsw_pkg::OC_WRITE_HIT;
                    state_next   = B_MRU1;
                end else begin
                    outcome_next = lsw_pkg::OC_WRITE_INSERT;
                    if ((occ_reg >= limit) && (occ_reg != '0)) begin
                        ent_re      = 1'b1;
                        ent_raddr   = lru_reg;
                        victim_next = lru_reg;
                        evict_next  = 1'b1;
                        state_next  = B_EV_RD;
                    end else begin
                        victim_next = SLOT_W'(occ_reg);
                        evict_next  = 1'b0;
                        state_next  = B_INS;
                    end
                end
            end
            B_MRU1: begin
                if (slot_reg == mru_reg) begin
                    state_next = B_OUT;
                end else begin
                    if (slot_reg == lru_reg) begin
                        lru_next = prev_rd_reg;
                    end else begin
                        prev_we = 1'b1;
                        next_we = 1'b1;
                    end
                    state_next = B_MRU2;
                end
            end
            B_MRU2: begin
                next_we    = 1'b1;
                next_waddr = slot_reg;
                next_wdata = mru_reg;
                prev_we    = 1'b1;
                prev_waddr = mru_reg;
                prev_wdata = slot_reg;
                mru_next   = slot_reg;
                state_next = B_OUT;
            end
            B_EV_RD: begin
                if (dirty_rd_reg != '0) begin
                    wb_valid_next = 1'b1;
                    wb_page_next  = page_rd_reg;
                    wb_mask_next  = stored_rd_reg;
                end
                if (occ_reg > BV_W'(1)) begin
                    lru_next = prev_rd_reg;
                end
                key_next         = page_rd_reg;
                probe_next       = home_rd_reg;
                victim_mode_next = 1'b1;
                state_next       = B_LK_BKT;
            end
            B_RM_BKT: begin
                bkt_re     = 1'b1;
                state_next = B_RM_ENT;
            end
            B_RM_ENT: begin
                if (bkt_rd_reg == '0) begin
                    state_next = B_INS;
                end else begin
                    ent_re     = 1'b1;
                    state_next = B_RM_CMP;
                end
            end
            B_RM_CMP: begin
                if (move) begin
                    bkt_we     = 1'b1;
                    bkt_waddr  = hole_reg;
                    bkt_wdata  = bkt_rd_reg;
                    hole_next  = probe_reg;
                    state_next = B_RM_ZERO;
                end else begin
                    probe_next = probe_inc;
                    state_next = B_RM_BKT;
                end
            end
            B_RM_ZERO: begin
                bkt_we     = 1'b1;
                bkt_waddr  = hole_reg;
                probe_next = hole_inc;
                state_next = B_RM_BKT;
            end
            B_INS: begin
                ent_we      = 1'b1;
                ent_waddr   = victim_reg;
                ent_wstored = cmd_reg.mask;
                ent_wdirty  = cmd_reg.mask;
                if (occ_after == '0) begin
                    mru_next = victim_reg;
                    lru_next = victim_reg;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = victim_reg;
                    next_wdata = mru_reg;
                    prev_we    = 1'b1;
                    prev_waddr = mru_reg;
                    prev_wdata = victim_reg;
                    mru_next   = victim_reg;
                end
                occ_next         = occ_after + 1'b1;
                probe_next       = home_reg;
                victim_mode_next = 1'b0;
                state_next       = B_BI_BKT;
            end
            B_BI_BKT: begin
                bkt_re     = 1'b1;
                state_next = B_BI_CHK;
            end
            B_BI_CHK: begin
                if (bkt_rd_reg == '0) begin
                    bkt_we     = 1'b1;
                    bkt_wdata  = BV_W'(victim_reg) + 1'b1;
                    state_next = B_OUT;
                end else begin
                    probe_next = probe_inc;
                    state_next = B_BI_BKT;
                end
            end
            B_OUT: begin
                if (!res_valid_reg || res_ready) begin
                    res_next.page_number     = cmd_reg.page;
                    res_next.sector_mask     = cmd_reg.mask;
                    res_next.outcome         = outcome_reg;
                    res_next.writeback_valid = wb_valid_reg;
                    res_next.writeback_page  = wb_page_reg;
                    res_next.writeback_mask  = wb_mask_reg;
                    res_next.last            = cmd_reg.last;
                    res_valid_next           = 1'b1;
                    state_next               = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            probe_reg     <= '0;
            mru_reg       <= '0;
            lru_reg       <= '0;
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            probe_reg     <= probe_next;
            mru_reg       <= mru_next;
            lru_reg       <= lru_next;
            occ_reg       <= occ_next;
            res_valid_reg <= res_valid_next;
        end
        cmd_reg         <= cmd_next;
        home_reg        <= home_next;
        key_reg         <= key_next;
        victim_mode_reg <= victim_mode_next;
        found_reg       <= found_next;
        slot_reg        <= slot_next;
        victim_reg      <= victim_next;
        evict_reg       <= evict_next;
        hole_reg        <= hole_next;
        outcome_reg     <= outcome_next;
        wb_valid_reg    <= wb_valid_next;
        wb_page_reg     <= wb_page_next;
        wb_mask_reg     <= wb_mask_next;
        res_reg         <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bucket_mem[bkt_waddr] <= bkt_wdata;
        end
        if (bkt_re) begin
            bkt_rd_reg <= bucket_mem[bkt_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            page_mem[ent_waddr]   <= ent_wpage;
            home_mem[ent_waddr]   <= home_reg;
            stored_mem[ent_waddr] <= ent_wstored;
            dirty_mem[ent_waddr]  <= ent_wdirty;
        end
        if (ent_re) begin
            page_rd_reg   <= page_mem[ent_raddr];
            home_rd_reg   <= home_mem[ent_raddr];
            stored_rd_reg <= stored_mem[ent_raddr];
            dirty_rd_reg  <= dirty_mem[ent_raddr];
            prev_rd_reg   <= prev_mem[ent_raddr];
            next_rd_reg   <= next_mem[ent_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
    end

endmodule

`default_nettype wire
